// ===== design/ggte_pkg.sv =====
// ----------------------------------------------------------------------------
// ggte_pkg: shared types and constants of the GCM tag engine
// Command and register codes, field constants and byte masking helpers.
// ----------------------------------------------------------------------------
package ggte_pkg;

  localparam int unsigned BLOCK_W  = 128;
  localparam int unsigned HALF_W   = 64;
  localparam int unsigned COUNT_W  = 5;
  localparam int unsigned TOTAL_W  = 61;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = '1;

  // Top byte of the GCM reduction constant 0xE1 followed by 120 zero bits.
  localparam logic [7:0] GF_REDUCE_TOP = 8'hE1;

  typedef enum logic [1:0] {
    CMD_AAD    = 2'd0,
    CMD_CIPHER = 2'd1,
    CMD_FINISH = 2'd2
  } cmd_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HASH_KEY_HI   = 3'd0,
    REG_HASH_KEY_LO   = 3'd1,
    REG_FINAL_MASK_HI = 3'd2,
    REG_FINAL_MASK_LO = 3'd3,
    REG_TAG_BYTES     = 3'd4
  } cfg_idx_e;

  // Clamp a byte count to at most a full block.
  function automatic logic [COUNT_W-1:0] clamp_count(logic [COUNT_W-1:0] n);
    logic [COUNT_W-1:0] r;
    r = (n > COUNT_W'(16)) ? COUNT_W'(16) : n;
    return r;
  endfunction

  // Mask that keeps the n leading bytes of a block, byte 0 in the top bits.
  function automatic logic [BLOCK_W-1:0] lead_mask(logic [COUNT_W-1:0] n);
    logic [BLOCK_W-1:0] m;
    logic [COUNT_W-1:0] nc;
    nc = clamp_count(n);
    m  = '0;
    for (int b = 0; b < 16; b++) begin
      m[BLOCK_W-1-8*b -: 8] = (COUNT_W'(b) < nc) ? 8'hFF : 8'h00;
    end
    return m;
  endfunction

  // Saturating add of a byte count to a running total.
  function automatic logic [TOTAL_W-1:0] sat_add(logic [TOTAL_W-1:0] total,
                                                 logic [COUNT_W-1:0] n);
    logic [TOTAL_W:0] sum;
    sum = {1'b0, total} + {{(TOTAL_W+1-COUNT_W){1'b0}}, n};
    return sum[TOTAL_W] ? TOTAL_MAX : sum[TOTAL_W-1:0];
  endfunction

endpackage

// ===== design/gcm_ghash_tag_engine_unit.sv =====
// ----------------------------------------------------------------------------
// gcm_ghash_tag_engine_unit: GCM authentication tag engine
// A finish beat passes the input stage register; its tag is then loaded into
// the output register, where it waits until it is taken.
// Throughput: one beat per cycle while no finish is held back; the accumulator
// loop runs through the single parallel, combinational GF(2^128) multiplier.
// A finish stalls only while an earlier tag is still waiting at the output.
// Reset clears accumulator, byte totals and valids; registers take defaults.
// ----------------------------------------------------------------------------
module gcm_ghash_tag_engine_unit (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [ggte_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [ggte_pkg::HALF_W-1:0]      cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [1:0]                       command_i,
  input  logic [ggte_pkg::HALF_W-1:0]      block_hi_i,
  input  logic [ggte_pkg::HALF_W-1:0]      block_lo_i,
  input  logic [ggte_pkg::COUNT_W-1:0]     byte_count_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [ggte_pkg::HALF_W-1:0]      tag_hi_o,
  output logic [ggte_pkg::HALF_W-1:0]      tag_lo_o
);
  import ggte_pkg::*;

  // Configuration registers.
  logic [BLOCK_W-1:0] hash_key_q;
  logic [BLOCK_W-1:0] final_mask_q;
  logic [COUNT_W-1:0] tag_bytes_q;

  // Input stage.
  logic               stage_valid_q;
  cmd_e               stage_cmd_q;
  logic [BLOCK_W-1:0] stage_data_q;
  logic [COUNT_W-1:0] stage_count_q;

  // Hash state.
  logic [BLOCK_W-1:0] accum_q, accum_d;
  logic [TOTAL_W-1:0] aad_total_q, aad_total_d;
  logic [TOTAL_W-1:0] cipher_total_q, cipher_total_d;

  // Result register.
  logic               out_valid_q;
  logic [BLOCK_W-1:0] tag_q, tag_d;

  logic               in_accept;
  logic               in_keep;
  logic               stage_fin;
  logic               stage_adv;
  logic [BLOCK_W-1:0] mult_x;
  logic [BLOCK_W-1:0] mult_z;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hash_key_q   <= '0;
      final_mask_q <= '0;
      tag_bytes_q  <= COUNT_W'(16);
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        REG_HASH_KEY_HI:   hash_key_q[BLOCK_W-1:HALF_W]   <= cfg_data_i;
        REG_HASH_KEY_LO:   hash_key_q[HALF_W-1:0]         <= cfg_data_i;
        REG_FINAL_MASK_HI: final_mask_q[BLOCK_W-1:HALF_W] <= cfg_data_i;
        REG_FINAL_MASK_LO: final_mask_q[HALF_W-1:0]       <= cfg_data_i;
        REG_TAG_BYTES:     tag_bytes_q                    <= cfg_data_i[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // A finish may only leave the stage once the result register is free.
  assign stage_fin  = (stage_cmd_q == CMD_FINISH);
  assign stage_adv  = stage_valid_q && !(stage_fin && out_valid_q && !out_ready_i);
  assign in_ready_o = !stage_valid_q || stage_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  // Unused commands and empty absorb beats leave no trace.
  always_comb begin
    in_keep = 1'b0;
    if (command_i == CMD_FINISH) begin
      in_keep = 1'b1;
    end else if (command_i inside {CMD_AAD, CMD_CIPHER}) begin
      in_keep = (byte_count_i != '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stage_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      stage_valid_q <= in_accept && in_keep;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept && in_keep) begin
      stage_cmd_q   <= cmd_e'(command_i);
      stage_data_q  <= {block_hi_i, block_lo_i} & lead_mask(byte_count_i);
      stage_count_q <= clamp_count(byte_count_i);
    end
  end

  // The length block carries both totals in bits.
  assign mult_x = accum_q ^ (stage_fin ? {aad_total_q, 3'b000, cipher_total_q, 3'b000}
                                       : stage_data_q);

  ggte_gf_mult u_gf_mult (
    .x_i (mult_x),
    .h_i (hash_key_q),
    .z_o (mult_z)
  );

  always_comb begin
    accum_d        = accum_q;
    aad_total_d    = aad_total_q;
    cipher_total_d = cipher_total_q;
    tag_d          = (mult_z ^ final_mask_q) & lead_mask(tag_bytes_q);
    if (stage_adv) begin
      case (stage_cmd_q)
        CMD_AAD: begin
          accum_d     = mult_z;
          aad_total_d = sat_add(aad_total_q, stage_count_q);
        end
        CMD_CIPHER: begin
          accum_d        = mult_z;
          cipher_total_d = sat_add(cipher_total_q, stage_count_q);
        end
        CMD_FINISH: begin
          accum_d        = '0;
          aad_total_d    = '0;
          cipher_total_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      accum_q        <= '0;
      aad_total_q    <= '0;
      cipher_total_q <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      accum_q        <= accum_d;
      aad_total_q    <= aad_total_d;
      cipher_total_q <= cipher_total_d;
      if (stage_adv && stage_fin) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (stage_adv && stage_fin) begin
      tag_q <= tag_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign tag_hi_o    = tag_q[BLOCK_W-1:HALF_W];
  assign tag_lo_o    = tag_q[HALF_W-1:0];

  // A held finish must block the input while the previous tag waits.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_valid_q && stage_fin && out_valid_q && !out_ready_i) |-> !in_ready_o)
    else $error("input taken while a finish beat is held back");

  // Finishing a message leaves the hash state cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (stage_adv && stage_fin) |=>
      (accum_q == '0 && aad_total_q == '0 && cipher_total_q == '0))
    else $error("hash state not cleared after finish");

  // A new tag only appears after a finish beat left the stage.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(stage_adv && stage_fin))
    else $error("tag raised without a finish beat");

endmodule

// ===== design/ggte_gf_mult.sv =====
// ----------------------------------------------------------------------------
// ggte_gf_mult: GF(2^128) multiplier in GCM bit order
// Fully parallel carry-less product followed by a two-fold reduction.
// ----------------------------------------------------------------------------
module ggte_gf_mult (
  input  logic [ggte_pkg::BLOCK_W-1:0] x_i,
  input  logic [ggte_pkg::BLOCK_W-1:0] h_i,
  output logic [ggte_pkg::BLOCK_W-1:0] z_o
);
  import ggte_pkg::*;

  localparam int unsigned PROD_W = 2 * BLOCK_W - 1;
  localparam int unsigned FOLD_W = BLOCK_W + 6;

  // Arrays are indexed by power of x: bit 0 is the msb of the word.
  logic [0:BLOCK_W-1] xa;
  logic [0:BLOCK_W-1] ha;
  logic [0:PROD_W-1]  prod;
  logic [0:FOLD_W-1]  fold1;
  logic [0:BLOCK_W-1] fold2;

  always_comb begin
    for (int k = 0; k < BLOCK_W; k++) begin
      xa[k] = x_i[BLOCK_W-1-k];
      ha[k] = h_i[BLOCK_W-1-k];
    end
  end

  always_comb begin
    prod = '0;
    for (int i = 0; i < BLOCK_W; i++) begin
      for (int j = 0; j < BLOCK_W; j++) begin
        prod[i+j] = prod[i+j] ^ (xa[i] & ha[j]);
      end
    end
  end

  // x^128 = 1 + x + x^2 + x^7; the first fold leaves six bits above x^127.
  always_comb begin
    fold1 = '0;
    for (int m = 0; m < BLOCK_W; m++) begin
      fold1[m] = prod[m];
    end
    for (int j = 0; j < PROD_W - BLOCK_W; j++) begin
      for (int t = 0; t < 8; t++) begin
        if (GF_REDUCE_TOP[7-t]) begin
          fold1[j+t] = fold1[j+t] ^ prod[BLOCK_W+j];
        end
      end
    end
  end

  always_comb begin
    fold2 = fold1[0:BLOCK_W-1];
    for (int j = 0; j < FOLD_W - BLOCK_W; j++) begin
      for (int t = 0; t < 8; t++) begin
        if (GF_REDUCE_TOP[7-t]) begin
          fold2[j+t] = fold2[j+t] ^ fold1[BLOCK_W+j];
        end
      end
    end
  end

  always_comb begin
    for (int k = 0; k < BLOCK_W; k++) begin
      z_o[BLOCK_W-1-k] = fold2[k];
    end
  end

endmodule
